// ----- rtl/tflp_pkg.sv -----
// shared types and constants for the text frame line parser
// no dependencies; used by tflp_line_core and text_frame_line_parser
`timescale 1ns / 1ps

package tflp_pkg;

   // result event codes
   localparam logic [1:0] EVT_NONE  = 2'd0;
   localparam logic [1:0] EVT_LINE  = 2'd1;
   localparam logic [1:0] EVT_FRAME = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] REG_LINE_END   = 2'd0;
   localparam logic [1:0] REG_LINE_START = 2'd1;
   localparam logic [1:0] REG_SEPARATOR  = 2'd2;

   // register reset values
   localparam logic [7:0] RST_LINE_END   = 8'd13;
   localparam logic [7:0] RST_LINE_START = 8'd10;
   localparam logic [7:0] RST_SEPARATOR  = 8'd9;

   // "Checksum" packed first char in low byte
   localparam logic [63:0] CHECKSUM_LABEL = 64'h6D75736B63656843;

   localparam logic [7:0] MINUS_CHAR = 8'h2D;
   localparam logic [7:0] ZERO_CHAR  = 8'h30;
   localparam logic [7:0] NINE_CHAR  = 8'h39;

   // magnitude clamp and the largest accumulator that may still take a digit
   localparam logic [31:0] MAG_LIMIT   = 32'h8000_0000;
   localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;
   localparam logic [31:0] ACC_LIM     = 32'd214748364;
   localparam logic [31:0] ACC_LIM_NINE = 32'd214748363;

   typedef struct packed {
      logic [7:0] line_end_char;
      logic [7:0] line_start_char;
      logic [7:0] separator_char;
   } cfg_type;

   typedef struct packed {
      logic [1:0]   event_res;
      logic         sum_ok;
      logic [63:0]  label_text;
      logic [7:0]   label_len;
      logic         has_separator;
      logic [7:0]   value_len;
      logic         value_is_number;
      logic signed [31:0] value_number;
   } result_type;

endpackage

// ----- rtl/tflp_line_core.sv -----
// per-byte parser state and result computation for the line parser
// depends on tflp_pkg
`timescale 1ns / 1ps

module tflp_line_core #(
   parameter int LINE_CAP = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                kind,
   input  logic [7:0]          rx_byte,
   input  tflp_pkg::cfg_type   cfg,
   output tflp_pkg::result_type result
);

   localparam int POS_W = $clog2(LINE_CAP + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] sep_pos_ff, sep_pos_in;
   logic             sep_seen_ff, sep_seen_in;
   logic [63:0]      label_ff, label_in;
   logic [POS_W-1:0] label_len_ff, label_len_in;
   logic [31:0]      acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic             numeric_ff, numeric_in;
   logic             closed_ff, closed_in;
   logic [7:0]       sum_ff, sum_in;

   logic             frame_end;
   logic             do_open;
   logic [3:0]       digit;
   logic [31:0]      acc_lim;
   logic [31:0]      value_out;

   assign frame_end = !closed_ff && (pos_ff == POS_W'(9)) && sep_seen_ff &&
                      (sep_pos_ff == POS_W'(9)) && (label_len_ff == POS_W'(8)) &&
                      (label_ff == tflp_pkg::CHECKSUM_LABEL);

   assign digit   = 4'(rx_byte - tflp_pkg::ZERO_CHAR);
   assign acc_lim = (digit == 4'd9) ? tflp_pkg::ACC_LIM_NINE : tflp_pkg::ACC_LIM;

   // signed value from magnitude and sign
   assign value_out = neg_ff ? (32'd0 - acc_ff) :
                      ((acc_ff > tflp_pkg::POS_MAX) ? tflp_pkg::POS_MAX : acc_ff);

   always_comb begin
      pos_in       = pos_ff;
      sep_pos_in   = sep_pos_ff;
      sep_seen_in  = sep_seen_ff;
      label_in     = label_ff;
      label_len_in = label_len_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      numeric_in   = numeric_ff;
      closed_in    = closed_ff;
      sum_in       = sum_ff;
      do_open      = 1'b0;
      result       = '0;
      result.event_res = tflp_pkg::EVT_NONE;

      if (step) begin
         if (kind) begin
            do_open = 1'b1;
            sum_in  = 8'd0;
         end else begin
            sum_in = sum_ff + rx_byte;
            if (frame_end) begin
               result.event_res = tflp_pkg::EVT_FRAME;
               result.sum_ok    = (sum_in == 8'd0);
               sum_in           = 8'd0;
               do_open          = 1'b1;
            end else if (rx_byte == cfg.line_start_char) begin
               do_open = 1'b1;
            end else if (closed_ff) begin
               // closed line: byte only summed
            end else if (rx_byte == cfg.line_end_char) begin
               result.event_res     = tflp_pkg::EVT_LINE;
               result.label_text    = label_ff;
               result.label_len     = 8'(label_len_ff);
               result.has_separator = sep_seen_ff;
               result.value_is_number = 1'b1;
               if (sep_seen_ff) begin
                  result.value_len       = 8'(pos_ff - sep_pos_ff);
                  result.value_is_number = numeric_ff;
                  result.value_number    = value_out;
               end
               closed_in = 1'b1;
            end else if (pos_ff < POS_W'(LINE_CAP)) begin
               pos_in = pos_ff + POS_W'(1);
               if (rx_byte == cfg.separator_char) begin
                  sep_pos_in  = pos_ff + POS_W'(1);
                  sep_seen_in = 1'b1;
                  acc_in      = 32'd0;
                  neg_in      = 1'b0;
                  numeric_in  = 1'b1;
               end else if (!sep_seen_ff) begin
                  for (int i = 0; i < 8; i++) begin
                     if (pos_ff == POS_W'(i)) label_in[i*8 +: 8] = rx_byte;
                  end
                  label_len_in = pos_ff + POS_W'(1);
               end else if (rx_byte == tflp_pkg::MINUS_CHAR && pos_ff == sep_pos_ff) begin
                  neg_in = 1'b1;
               end else if (rx_byte >= tflp_pkg::ZERO_CHAR && rx_byte <= tflp_pkg::NINE_CHAR &&
                            numeric_ff) begin
                  if (acc_ff > acc_lim) acc_in = tflp_pkg::MAG_LIMIT;
                  else acc_in = (acc_ff << 3) + (acc_ff << 1) + 32'(digit);
               end else begin
                  numeric_in = 1'b0;
               end
            end
         end
      end

      if (do_open) begin
         pos_in       = '0;
         sep_pos_in   = '0;
         sep_seen_in  = 1'b0;
         label_in     = '0;
         label_len_in = '0;
         acc_in       = 32'd0;
         neg_in       = 1'b0;
         numeric_in   = 1'b1;
         closed_in    = frame_end && step && !kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         sep_pos_ff   <= '0;
         sep_seen_ff  <= 1'b0;
         label_ff     <= '0;
         label_len_ff <= '0;
         acc_ff       <= 32'd0;
         neg_ff       <= 1'b0;
         numeric_ff   <= 1'b1;
         closed_ff    <= 1'b0;
         sum_ff       <= 8'd0;
      end else begin
         pos_ff       <= pos_in;
         sep_pos_ff   <= sep_pos_in;
         sep_seen_ff  <= sep_seen_in;
         label_ff     <= label_in;
         label_len_ff <= label_len_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         numeric_ff   <= numeric_in;
         closed_ff    <= closed_in;
         sum_ff       <= sum_in;
      end
   end

endmodule

// ----- rtl/text_frame_line_parser.sv -----
// top level of the text frame line parser: csr registers, core, result buffer
// depends on tflp_pkg and tflp_line_core
`timescale 1ns / 1ps

// usage
// - req channel: one transaction per received byte; req_tdata[7:0] is the byte,
//   req_tuser is the kind (0 byte, 1 restart: clear sum and open a fresh line)
// - rsp channel: exactly one transaction per req transaction, in order;
//   rsp_tuser is the event (none, line complete, frame end), rsp_tdata the fields
// - csr port: apb style, line end / line start / separator chars at 0x0/0x4/0x8;
//   write only while the block is idle
// - result: registered in the output register, or parked in the skid register during a stall
// - throughput: one byte per cycle while req_tready is high; the per-byte parse is one combinational pass
//   from the parser state registers into the result register
// - stall: a two-entry result buffer (output register plus skid register) lets
//   one more byte in while a result waits; req_tready drops only when both hold
// - reset: synchronous; clears parser state, sum and buffer, chars to 13/10/9

module text_frame_line_parser #(
   parameter int LINE_CAP = 128
) (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   input  logic         req_tuser,   // [0] kind
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // [0] sum_ok, [64:1] label_text, [72:65] label_len,
                                     // [73] has_separator, [81:74] value_len,
                                     // [82] value_is_number, [114:83] value_number, rest 0
   output logic [1:0]   rsp_tuser,   // [1:0] event_res
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   tflp_pkg::cfg_type    cfg_ff;
   tflp_pkg::result_type core_result;
   tflp_pkg::result_type out_ff, out_in;
   tflp_pkg::result_type skid_ff, skid_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;

   logic req_take;
   logic rsp_take;
   logic csr_write;

   // ---------------- csr registers ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_end_char   <= tflp_pkg::RST_LINE_END;
         cfg_ff.line_start_char <= tflp_pkg::RST_LINE_START;
         cfg_ff.separator_char  <= tflp_pkg::RST_SEPARATOR;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            tflp_pkg::REG_LINE_END:   cfg_ff.line_end_char   <= csr_pwdata[7:0];
            tflp_pkg::REG_LINE_START: cfg_ff.line_start_char <= csr_pwdata[7:0];
            tflp_pkg::REG_SEPARATOR:  cfg_ff.separator_char  <= csr_pwdata[7:0];
            default: ;  // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         tflp_pkg::REG_LINE_END:   csr_prdata = {24'd0, cfg_ff.line_end_char};
         tflp_pkg::REG_LINE_START: csr_prdata = {24'd0, cfg_ff.line_start_char};
         tflp_pkg::REG_SEPARATOR:  csr_prdata = {24'd0, cfg_ff.separator_char};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // ---------------- parser core ----------------
   assign req_tready = !skid_valid_ff;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = out_valid_ff && rsp_tready;

   tflp_line_core #(
      .LINE_CAP (LINE_CAP)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (req_take),
      .kind    (req_tuser),
      .rx_byte (req_tdata),
      .cfg     (cfg_ff),
      .result  (core_result)
   );

   // ---------------- result buffer ----------------
   // skid holds a result only when the output register is stalled and full
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || rsp_take) begin
            out_in       = core_result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = core_result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.event_res;
   assign rsp_tdata  = {5'd0, out_ff.value_number, out_ff.value_is_number, out_ff.value_len,
                        out_ff.has_separator, out_ff.label_len, out_ff.label_text,
                        out_ff.sum_ok};

   // ---------------- assertions ----------------
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (req_take && out_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("result taken during stall was not parked in skid register");

   a_sum_ok_frame_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != tflp_pkg::EVT_FRAME) |-> !rsp_tdata[0])
      else $error("sum_ok set on a result that is not a frame end");

   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == tflp_pkg::EVT_NONE || rsp_tuser == tflp_pkg::EVT_LINE ||
                      rsp_tuser == tflp_pkg::EVT_FRAME))
      else $error("undefined event code on result");

endmodule

// ----- dv/text_frame_line_parser_tb.sv -----
// self-checking testbench for text_frame_line_parser: directed and random byte streams,
// checked against a cycle-free parser predictor in the bench
// depends on tflp_pkg and the rtl of text_frame_line_parser
`timescale 1ns / 1ps

module text_frame_line_parser_tb;

   localparam int LINE_CAP   = 128;
   localparam int MAX_PRINTS = 40;

   // receiver behavior, picked anew whenever its random hold count runs out
   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_BURSTY} rx_mode_type;

   logic          clock        = 1'b0;
   logic          reset        = 1'b1;
   logic          req_tvalid   = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata    = 8'd0;   // [7:0] rx_byte
   logic          req_tuser    = 1'b0;   // [0] kind
   logic          rsp_tvalid;
   logic          rsp_tready   = 1'b0;
   logic [119:0]  rsp_tdata;             // [0] sum_ok, [64:1] label_text, [72:65] label_len,
                                         // [73] has_separator, [81:74] value_len,
                                         // [82] value_is_number, [114:83] value_number
   logic [1:0]    rsp_tuser;             // [1:0] event_res
   logic          csr_psel     = 1'b0;
   logic          csr_penable  = 1'b0;
   logic          csr_pwrite   = 1'b0;
   logic [3:0]    csr_paddr    = 4'd0;
   logic [31:0]   csr_pwdata   = 32'd0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   // parser predictor: control chars as last written, and the line state
   logic [7:0]    end_char      = tflp_pkg::RST_LINE_END;
   logic [7:0]    start_char    = tflp_pkg::RST_LINE_START;
   logic [7:0]    sep_char      = tflp_pkg::RST_SEPARATOR;
   logic [7:0]    pos           = 8'd0;
   logic [7:0]    sep_pos       = 8'd0;
   logic          sep_seen      = 1'b0;
   logic [63:0]   label_acc     = 64'd0;
   logic [7:0]    label_count   = 8'd0;
   logic [31:0]   mag_acc       = 32'd0;
   logic          neg_value     = 1'b0;
   logic          numeric_value = 1'b1;
   logic          closed        = 1'b0;
   logic [7:0]    running_sum   = 8'd0;

   tflp_pkg::result_type expected_results[$];
   int            fail_count  = 0;
   int            items_sent  = 0;
   int            burst_left  = 0;
   rx_mode_type   rx_mode     = RX_ALWAYS;
   int            rx_hold     = 0;

   text_frame_line_parser #(.LINE_CAP(LINE_CAP)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // run limit, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------------------

   // fresh line: position, label and value all cleared, line open
   function automatic void begin_line();
      pos           = 8'd0;
      sep_pos       = 8'd0;
      sep_seen      = 1'b0;
      label_acc     = 64'd0;
      label_count   = 8'd0;
      mag_acc       = 32'd0;
      neg_value     = 1'b0;
      numeric_value = 1'b1;
      closed        = 1'b0;
   endfunction

   // negative values reach -2^31 through the magnitude clamp, positive ones clip at max
   function automatic logic [31:0] signed_value();
      if (neg_value)
         return 32'd0 - mag_acc;
      return (mag_acc > tflp_pkg::POS_MAX) ? tflp_pkg::POS_MAX : mag_acc;
   endfunction

   // one byte stored into an open line that still has room
   function automatic void absorb_byte(input logic [7:0] data);
      logic [31:0] digit;
      digit = {24'd0, data - tflp_pkg::ZERO_CHAR};
      if (data == sep_char) begin
         // every separator restarts the value; the label stays as it was
         pos           = pos + 8'd1;
         sep_pos       = pos;
         sep_seen      = 1'b1;
         mag_acc       = 32'd0;
         neg_value     = 1'b0;
         numeric_value = 1'b1;
      end else if (!sep_seen) begin
         if (pos < 8)
            label_acc[8*pos +: 8] = data;
         pos         = pos + 8'd1;
         label_count = pos;
      end else begin
         if (data == tflp_pkg::MINUS_CHAR && pos == sep_pos) begin
            neg_value = 1'b1;
         end else if (data >= tflp_pkg::ZERO_CHAR && data <= tflp_pkg::NINE_CHAR &&
                      numeric_value) begin
            if (mag_acc > (tflp_pkg::MAG_LIMIT - digit) / 32'd10)
               mag_acc = tflp_pkg::MAG_LIMIT;
            else
               mag_acc = mag_acc * 32'd10 + digit;
         end else begin
            numeric_value = 1'b0;
         end
         pos = pos + 8'd1;
      end
   endfunction

   // expected result of one accepted request transaction; state moves on with it
   function automatic void parse_byte(input logic kind, input logic [7:0] data);
      tflp_pkg::result_type r;
      r = '0;
      if (kind) begin
         begin_line();
         running_sum = 8'd0;
      end else begin
         running_sum = running_sum + data;
         // the byte right after "Checksum" and its separator closes the frame,
         // whatever its value
         if (!closed && pos == 8'd9 && sep_seen && sep_pos == 8'd9 && label_count == 8'd8 &&
             label_acc == tflp_pkg::CHECKSUM_LABEL) begin
            r.event_res = tflp_pkg::EVT_FRAME;
            r.sum_ok    = (running_sum == 8'd0);
            running_sum = 8'd0;
            begin_line();
            closed      = 1'b1;
         end else if (data == start_char) begin
            begin_line();
         end else if (closed) begin
            // between a line end and the next line start: summed only
         end else if (data == end_char) begin
            r.event_res     = tflp_pkg::EVT_LINE;
            r.label_text    = label_acc;
            r.label_len     = label_count;
            r.has_separator = sep_seen;
            if (sep_seen) begin
               r.value_len       = pos - sep_pos;
               r.value_is_number = numeric_value;
               r.value_number    = signed_value();
            end else begin
               r.value_is_number = 1'b1;
            end
            closed = 1'b1;
         end else if (pos < LINE_CAP) begin
            absorb_byte(data);
         end
      end
      expected_results.push_back(r);
   endfunction

   // ---------------------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      if (fail_count <= MAX_PRINTS)
         $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
   endtask

   // every rsp transaction is matched against the oldest expectation
   always @(posedge clock) begin
      tflp_pkg::result_type got_r;
      tflp_pkg::result_type want_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_r.event_res       = rsp_tuser;
         got_r.sum_ok          = rsp_tdata[0];
         got_r.label_text      = rsp_tdata[64:1];
         got_r.label_len       = rsp_tdata[72:65];
         got_r.has_separator   = rsp_tdata[73];
         got_r.value_len       = rsp_tdata[81:74];
         got_r.value_is_number = rsp_tdata[82];
         got_r.value_number    = rsp_tdata[114:83];
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transaction", {62'd0, got_r.event_res}, 64'd0);
         end else begin
            want_r = expected_results.pop_front();
            if (got_r.event_res != want_r.event_res)
               report_mismatch("event_res", 64'(got_r.event_res), 64'(want_r.event_res));
            if (got_r.sum_ok != want_r.sum_ok)
               report_mismatch("sum_ok", 64'(got_r.sum_ok), 64'(want_r.sum_ok));
            if (got_r.label_text != want_r.label_text)
               report_mismatch("label_text", got_r.label_text, want_r.label_text);
            if (got_r.label_len != want_r.label_len)
               report_mismatch("label_len", 64'(got_r.label_len), 64'(want_r.label_len));
            if (got_r.has_separator != want_r.has_separator)
               report_mismatch("has_separator", 64'(got_r.has_separator),
                               64'(want_r.has_separator));
            if (got_r.value_len != want_r.value_len)
               report_mismatch("value_len", 64'(got_r.value_len), 64'(want_r.value_len));
            if (got_r.value_is_number != want_r.value_is_number)
               report_mismatch("value_is_number", 64'(got_r.value_is_number),
                               64'(want_r.value_is_number));
            if (got_r.value_number != want_r.value_number)
               report_mismatch("value_number", 64'(got_r.value_number),
                               64'(want_r.value_number));
         end
      end
   end

   // receiver stalls: long stretches always ready, others random, sparse or mostly stalled
   always @(posedge clock) begin
      if (rx_hold == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_hold <= $urandom_range(20, 200);
      end else begin
         rx_hold <= rx_hold - 1;
      end
      case (rx_mode)
         RX_ALWAYS: rsp_tready <= 1'b1;
         RX_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= (rx_hold % 4 == 0);
         default:   rsp_tready <= ($urandom_range(0, 9) > 6);
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // stimulus primitives
   // ---------------------------------------------------------------------------------------

   // one request transaction; the sender pauses between bursts of random length
   task automatic send_item(input logic kind, input logic [7:0] data);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do begin
         @(posedge clock);
      end while (!req_tready);
      parse_byte(kind, data);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                  : $urandom_range(0, 10);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // stop sending and let every outstanding result drain
   task automatic wait_idle();
      if (req_tvalid)
         req_tvalid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // apb setup plus access phase; reads are compared with the value last written
   task automatic csr_access(input logic is_write, input logic [1:0] index,
                             input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      if (!is_write && csr_prdata != {24'd0, value})
         report_mismatch("csr readback", 64'(csr_prdata), {56'd0, value});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
      csr_access(1'b1, index, value);
      case (index)
         tflp_pkg::REG_LINE_END:   end_char   = value;
         tflp_pkg::REG_LINE_START: start_char = value;
         default:                  sep_char   = value;
      endcase
      csr_access(1'b0, index, value);
   endtask

   task automatic apply_setting(input logic [7:0] e, input logic [7:0] s, input logic [7:0] sp);
      wait_idle();
      write_reg(tflp_pkg::REG_LINE_END, e);
      write_reg(tflp_pkg::REG_LINE_START, s);
      write_reg(tflp_pkg::REG_SEPARATOR, sp);
   endtask

   // text byte that is none of the control chars; mostly printable
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do begin
         c = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
      end while (c == start_char || c == end_char || c == sep_char);
      return c;
   endfunction

   task automatic send_digits(input int n);
      repeat (n) send_item(1'b0, tflp_pkg::ZERO_CHAR + 8'($urandom_range(0, 9)));
   endtask

   // value text: numbers of all sizes, saturation boundaries, lone minus, junk
   task automatic send_value();
      string txt;
      txt = "";
      case ($urandom_range(0, 6))
         0: ;  // empty value
         1: begin
            if ($urandom_range(0, 1)) send_item(1'b0, tflp_pkg::MINUS_CHAR);
            send_digits($urandom_range(1, 6));
         end
         2: begin
            if ($urandom_range(0, 1)) send_item(1'b0, tflp_pkg::MINUS_CHAR);
            send_digits($urandom_range(9, 14));
         end
         3: begin
            case ($urandom_range(0, 5))
               0: txt = "2147483647";
               1: txt = "2147483648";
               2: txt = "-2147483648";
               3: txt = "-2147483649";
               4: txt = "214748364";
               default: txt = "4294967296";
            endcase
            for (int i = 0; i < txt.len(); i++)
               send_item(1'b0, txt[i]);
         end
         4: send_item(1'b0, tflp_pkg::MINUS_CHAR);
         5: begin
            // digits broken by a stray char or a late minus
            send_digits($urandom_range(1, 4));
            send_item(1'b0, $urandom_range(0, 1) ? tflp_pkg::MINUS_CHAR : plain_char());
            send_digits($urandom_range(0, 3));
         end
         default: repeat ($urandom_range(1, 8)) send_item(1'b0, plain_char());
      endcase
   endtask

   // a label/value line, now and then broken: no start, no end, or trailing bytes
   task automatic send_line();
      int label_n;
      if ($urandom_range(0, 9) != 0)
         send_item(1'b0, start_char);
      // a few lines overrun the line capacity
      label_n = ($urandom_range(0, 24) == 0) ? $urandom_range(LINE_CAP - 8, LINE_CAP + 12)
                                             : $urandom_range(0, 12);
      repeat (label_n) send_item(1'b0, plain_char());
      if ($urandom_range(0, 9) != 0) begin
         send_item(1'b0, sep_char);
         send_value();
         if ($urandom_range(0, 6) == 0) begin
            send_item(1'b0, sep_char);
            send_value();
         end
      end
      if ($urandom_range(0, 9) != 0)
         send_item(1'b0, end_char);
      // bytes after the line end are summed but not parsed
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 4))
            send_item(1'b0, $urandom_range(0, 1) ? ($urandom_range(0, 1) ? sep_char : end_char)
                                                 : plain_char());
   endtask

   task automatic send_checksum_line();
      send_item(1'b0, start_char);
      for (int i = 0; i < 8; i++)
         send_item(1'b0, tflp_pkg::CHECKSUM_LABEL[8*i +: 8]);
      send_item(1'b0, sep_char);
   endtask

   // some lines and then the checksum line, mostly with a sum that comes out zero
   task automatic send_frame();
      repeat ($urandom_range(1, 4)) send_line();
      send_checksum_line();
      case ($urandom_range(0, 7))
         0: send_item(1'b0, $urandom_range(0, 1) ? end_char
                                                 : ($urandom_range(0, 1) ? sep_char : start_char));
         1: send_item(1'b0, 8'($urandom_range(0, 255)));
         default: send_item(1'b0, 8'd0 - running_sum);
      endcase
      if ($urandom_range(0, 3) == 0)
         send_item(1'b0, end_char);
   endtask

   // mostly well formed frames and lines, the rest noise and restarts
   task automatic run_random_stream(input int n_items);
      int stop_at;
      int pick;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            send_line();
         else if (pick < 82)
            send_frame();
         else if (pick < 94)
            repeat ($urandom_range(1, 8))
               send_item($urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)));
         else
            send_item(1'b1, 8'($urandom_range(0, 255)));
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // restart, a clean frame end, a closed-line byte, a line with zero and 0xff bytes,
   // a minus, two separators, and an empty line
   task automatic test_directed_frame();
      send_item(1'b1, 8'hFF);
      send_checksum_line();
      send_item(1'b0, 8'd0 - running_sum);
      send_item(1'b0, end_char);
      send_item(1'b0, start_char);
      send_item(1'b0, 8'h58);
      send_item(1'b0, 8'h00);
      send_item(1'b0, sep_char);
      send_item(1'b0, tflp_pkg::MINUS_CHAR);
      send_item(1'b0, tflp_pkg::NINE_CHAR);
      send_item(1'b0, sep_char);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, end_char);
      send_item(1'b0, start_char);
      send_item(1'b0, end_char);
   endtask

   task automatic test_default_traffic();
      run_random_stream(400);
   endtask

   // control chars at the extremes, coinciding, and overlapping the value syntax
   task automatic test_char_settings();
      apply_setting(8'h00, 8'hFF, 8'h80);
      run_random_stream(90);
      apply_setting(8'hFF, 8'h00, 8'h01);
      run_random_stream(90);
      apply_setting(8'h0D, 8'h0D, 8'h0D);
      run_random_stream(80);
      apply_setting(8'h3B, 8'h3B, 8'h3A);
      run_random_stream(80);
      apply_setting(8'h0D, 8'h0A, 8'h0D);
      run_random_stream(80);
      apply_setting(8'h21, tflp_pkg::MINUS_CHAR, 8'h35);
      run_random_stream(80);
      apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      run_random_stream(80);
      apply_setting(tflp_pkg::RST_LINE_END, tflp_pkg::RST_LINE_START, tflp_pkg::RST_SEPARATOR);
      run_random_stream(60);
   endtask

   // raw bytes with frequent restarts, no structure at all
   task automatic test_restart_noise();
      repeat (100) send_item($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frame();
      test_default_traffic();
      test_char_settings();
      test_restart_noise();
      wait_idle();
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- text_frame_line_parser.f -----
rtl/tflp_pkg.sv
rtl/tflp_line_core.sv
rtl/text_frame_line_parser.sv
dv/text_frame_line_parser_tb.sv
